[rtl/csaip_pkg.sv]
// ----------------------------------------------------------------------------
// csaip_pkg
// Types and constants shared by the sample auxiliary info parser.
// ----------------------------------------------------------------------------
`default_nettype none

package csaip_pkg;

    // Longest IV kept; bytes beyond this are consumed with no IV result
    localparam int IV_BYTES = 16;

    // Bytes in the subsample count field and in one subsample entry
    localparam logic [6:0] COUNT_BYTES = 7'd2;
    localparam logic [6:0] ENTRY_BYTES = 7'd6;

    // Result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_IV    = 2'd1,
        PH_COUNT = 2'd2,
        PH_ENTRY = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_IV    = 2'd0,
        KIND_ENTRY = 2'd1,
        KIND_END   = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t        kind;
        logic [3:0]   iv_index;
        logic [7:0]   iv_value;
        logic [15:0]  entry_index;
        logic [15:0]  clear_size;
        logic [31:0]  encrypted_bytes;
        logic [15:0]  entry_total;
        logic [18:0]  header_length;
        logic [23:0]  remaining_size;
        logic         last;
        logic         error;
    } result_t;

    // Results made by one input beat: up to two, in order
    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } push_t;

endpackage

`default_nettype wire

[rtl/csaip_parse.sv]
// ----------------------------------------------------------------------------
// csaip_parse
// Header field state and per-byte result generation.
// ----------------------------------------------------------------------------
`default_nettype none

module csaip_parse
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            accept,
    input  wire logic [7:0]      data_byte,
    input  wire logic            start_req,
    input  wire logic [23:0]     sample_size,
    output csaip_pkg::push_t     push
);

    csaip_pkg::phase_t phase_reg, phase_next;
    logic        sub_reg, sub_next;
    logic [6:0]  iv_len_reg, iv_len_next;
    logic [6:0]  fbc_reg, fbc_next;
    logic [15:0] ecount_reg, ecount_next;
    logic [15:0] epos_reg, epos_next;
    logic [39:0] shift_reg, shift_next;
    logic [18:0] cons_reg, cons_next;
    logic [23:0] stotal_reg, stotal_next;
    logic        err_reg, err_next;

    // Values after consuming this byte
    logic [18:0] cons_n;
    logic [23:0] stotal_n;
    logic        err_n;
    logic [23:0] rem;
    logic [6:0]  fbc_inc;
    logic [15:0] sh16;
    logic [47:0] sh48;
    logic        iv_end;
    logic        iv_hit;
    logic        entry_last;
    csaip_pkg::result_t base, single;

    assign cons_n   = start_req ? 19'd1 : cons_reg + 19'd1;
    assign stotal_n = start_req ? sample_size : stotal_reg;
    assign err_n    = (start_req ? 1'b0 : err_reg)
                    | ({5'd0, cons_n} > stotal_n)
                    | (start_req && (data_byte[6:0] > 7'(csaip_pkg::IV_BYTES)));
    assign rem      = ({5'd0, cons_n} >= stotal_n) ? 24'd0 : stotal_n - {5'd0, cons_n};

    assign fbc_inc    = fbc_reg + 7'd1;
    assign sh16       = {shift_reg[7:0], data_byte};
    assign sh48       = {shift_reg, data_byte};
    assign iv_end     = fbc_inc >= iv_len_reg;
    assign iv_hit     = fbc_reg < 7'(csaip_pkg::IV_BYTES);
    assign entry_last = ({1'b0, epos_reg} + 17'd1) == {1'b0, ecount_reg};

    // Next state
    always_comb
    begin
        phase_next  = phase_reg;
        sub_next    = sub_reg;
        iv_len_next = iv_len_reg;
        fbc_next    = fbc_reg;
        ecount_next = ecount_reg;
        epos_next   = epos_reg;
        shift_next  = shift_reg;
        cons_next   = cons_reg;
        stotal_next = stotal_reg;
        err_next    = err_reg;
        if (accept)
        begin
            if (start_req)
            begin
                sub_next    = data_byte[7];
                iv_len_next = data_byte[6:0];
                stotal_next = sample_size;
                err_next    = err_n;
                cons_next   = cons_n;
                ecount_next = 16'd0;
                epos_next   = 16'd0;
                shift_next  = '0;
                fbc_next    = 7'd0;
                if (data_byte[6:0] == 7'd0)
                begin
                    if (data_byte[7])
                    begin
                        phase_next = csaip_pkg::PH_COUNT;
                    end
                    else
                    begin
                        phase_next  = csaip_pkg::PH_IDLE;
                        ecount_next = 16'd1;
                    end
                end
                else
                begin
                    phase_next = csaip_pkg::PH_IV;
                end
            end
            else
            begin
                case (phase_reg)
                    csaip_pkg::PH_IV:
                    begin
                        cons_next = cons_n;
                        err_next  = err_n;
                        fbc_next  = fbc_inc;
                        if (iv_end)
                        begin
                            fbc_next   = 7'd0;
                            shift_next = '0;
                            if (sub_reg)
                            begin
                                phase_next = csaip_pkg::PH_COUNT;
                            end
                            else
                            begin
                                phase_next  = csaip_pkg::PH_IDLE;
                                ecount_next = 16'd1;
                            end
                        end
                    end
                    csaip_pkg::PH_COUNT:
                    begin
                        cons_next = cons_n;
                        err_next  = err_n;
                        if (fbc_inc < csaip_pkg::COUNT_BYTES)
                        begin
                            fbc_next   = fbc_inc;
                            shift_next = sh48[39:0];
                        end
                        else
                        begin
                            ecount_next = sh16;
                            epos_next   = 16'd0;
                            fbc_next    = 7'd0;
                            shift_next  = '0;
                            phase_next  = (sh16 == 16'd0) ? csaip_pkg::PH_IDLE
                                                          : csaip_pkg::PH_ENTRY;
                        end
                    end
                    csaip_pkg::PH_ENTRY:
                    begin
                        cons_next = cons_n;
                        err_next  = err_n;
                        if (fbc_inc < csaip_pkg::ENTRY_BYTES)
                        begin
                            fbc_next   = fbc_inc;
                            shift_next = sh48[39:0];
                        end
                        else
                        begin
                            fbc_next   = 7'd0;
                            shift_next = '0;
                            epos_next  = epos_reg + 16'd1;
                            if (entry_last)
                            begin
                                phase_next = csaip_pkg::PH_IDLE;
                            end
                        end
                    end
                    default:
                    begin
                        // idle byte with no start: ignored
                    end
                endcase
            end
        end
    end

    // Result generation
    always_comb
    begin
        base                = '0;
        base.header_length  = cons_n;
        base.remaining_size = rem;
        base.error          = err_n;

        // single entry for a header without subsamples
        single                 = base;
        single.kind            = csaip_pkg::KIND_ENTRY;
        single.encrypted_bytes = {8'd0, rem};
        single.entry_total     = 16'd1;
        single.last            = 1'b1;

        push       = '0;
        push.res0  = base;
        push.res1  = base;
        if (accept)
        begin
            if (start_req)
            begin
                if ((data_byte[6:0] == 7'd0) && !data_byte[7])
                begin
                    push.res0  = single;
                    push.count = 2'd1;
                end
            end
            else
            begin
                case (phase_reg)
                    csaip_pkg::PH_IV:
                    begin
                        if (iv_hit)
                        begin
                            push.res0.kind     = csaip_pkg::KIND_IV;
                            push.res0.iv_index = fbc_reg[3:0];
                            push.res0.iv_value = data_byte;
                            push.count         = 2'd1;
                        end
                        if (iv_end && !sub_reg)
                        begin
                            if (iv_hit)
                            begin
                                push.res1  = single;
                                push.count = 2'd2;
                            end
                            else
                            begin
                                push.res0  = single;
                                push.count = 2'd1;
                            end
                        end
                    end
                    csaip_pkg::PH_COUNT:
                    begin
                        if (!(fbc_inc < csaip_pkg::COUNT_BYTES) && (sh16 == 16'd0))
                        begin
                            push.res0.kind = csaip_pkg::KIND_END;
                            push.res0.last = 1'b1;
                            push.count     = 2'd1;
                        end
                    end
                    csaip_pkg::PH_ENTRY:
                    begin
                        if (!(fbc_inc < csaip_pkg::ENTRY_BYTES))
                        begin
                            push.res0.kind            = csaip_pkg::KIND_ENTRY;
                            push.res0.entry_index     = epos_reg;
                            push.res0.clear_size      = sh48[47:32];
                            push.res0.encrypted_bytes = sh48[31:0];
                            push.res0.entry_total     = ecount_reg;
                            push.res0.last            = entry_last;
                            push.count                = 2'd1;
                        end
                    end
                    default:
                    begin
                        push.count = 2'd0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= csaip_pkg::PH_IDLE;
            sub_reg    <= 1'b0;
            iv_len_reg <= 7'd0;
            fbc_reg    <= 7'd0;
            ecount_reg <= 16'd0;
            epos_reg   <= 16'd0;
            shift_reg  <= '0;
            cons_reg   <= 19'd0;
            stotal_reg <= 24'd0;
            err_reg    <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            sub_reg    <= sub_next;
            iv_len_reg <= iv_len_next;
            fbc_reg    <= fbc_next;
            ecount_reg <= ecount_next;
            epos_reg   <= epos_next;
            shift_reg  <= shift_next;
            cons_reg   <= cons_next;
            stotal_reg <= stotal_next;
            err_reg    <= err_next;
        end
    end

endmodule

`default_nettype wire

[rtl/csaip_rq.sv]
// ----------------------------------------------------------------------------
// csaip_rq
// Small result queue: takes up to two results a cycle, gives one per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module csaip_rq
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire csaip_pkg::push_t   push,
    output logic                    space,
    output logic                    valid,
    input  wire logic               pop,
    output csaip_pkg::result_t      head
);

    csaip_pkg::result_t mem_reg [csaip_pkg::FIFO_DEPTH];

    logic [csaip_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [csaip_pkg::FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [csaip_pkg::FIFO_CNT_W-1:0] count_reg, count_next;
    logic [csaip_pkg::FIFO_PTR_W-1:0] wr_ptr_inc;
    logic                             do_pop;

    assign valid      = count_reg != '0;
    assign space      = count_reg <= csaip_pkg::FIFO_CNT_W'(csaip_pkg::FIFO_DEPTH - 2);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && valid;
    assign wr_ptr_inc = wr_ptr_reg + csaip_pkg::FIFO_PTR_W'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + csaip_pkg::FIFO_PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + csaip_pkg::FIFO_PTR_W'(do_pop);
        count_next  = count_reg + csaip_pkg::FIFO_CNT_W'(push.count)
                    - csaip_pkg::FIFO_CNT_W'(do_pop);
    end

    // storage: payload only, no reset
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.res0;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_inc] <= push.res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

[rtl/cenc_sample_aux_info_parser.sv]
// Results of a header byte are formed combinationally and written into the queue.
// Throughput: one header byte per cycle while the queue has room. Only a last IV byte
// within IV_BYTES, in a header without subsamples, gives two results, one beat each.
// The input stalls only when the four-entry result queue holds more than two results.
// Reset (rst_n low, asynchronous): parser idle, all counts cleared, queue empty.
// ----------------------------------------------------------------------------
// cenc_sample_aux_info_parser
// Parses the per-sample encryption auxiliary header one byte per beat and
// reports IV bytes and subsample entries.
// ----------------------------------------------------------------------------
`default_nettype none

module cenc_sample_aux_info_parser
(
    input  wire logic          clk,
    input  wire logic          rst_n,

    // Header byte stream
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [31:0]   s_tdata,   // data_byte[7:0], sample_size[31:8]
    input  wire logic          s_tuser,   // start_req

    // Result stream
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [135:0]       m_tdata,   // iv_index[3:0], iv_value[11:4],
                                          // entry_index[27:12], clear_size[43:28],
                                          // encrypted_bytes[75:44],
                                          // entry_total[91:76],
                                          // header_length[110:92],
                                          // remaining_size[134:111], error[135]
    output logic [1:0]         m_tuser,   // kind
    output logic               m_tlast    // last
);

    logic               accept;
    csaip_pkg::push_t   push;
    csaip_pkg::result_t head;

    assign accept = s_tvalid && s_tready;

    // Field parser: all the work for a byte is done in the cycle it is taken.
    // Results land straight in the queue, which serves as the result register.
    csaip_parse u_parse
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_byte   (s_tdata[7:0]),
        .start_req   (s_tuser),
        .sample_size (s_tdata[31:8]),
        .push        (push)
    );

    // Queue takes a byte only while it has room for two results, so both results
    // of any byte always fit.
    csaip_rq u_rq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .space (s_tready),
        .valid (m_tvalid),
        .pop   (m_tready),
        .head  (head)
    );

    assign m_tuser = head.kind;
    assign m_tlast = head.last;
    assign m_tdata = {head.error,
                      head.remaining_size,
                      head.header_length,
                      head.entry_total,
                      head.encrypted_bytes,
                      head.clear_size,
                      head.entry_index,
                      head.iv_value,
                      head.iv_index};

    // An end-of-header marker always closes the header
    a_end_is_last : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == csaip_pkg::KIND_END)) |-> m_tlast)
        else $error("header end result without last");

    // IV bytes never close a header
    a_iv_not_last : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == csaip_pkg::KIND_IV)) |-> !m_tlast)
        else $error("IV result marked last");

    // Input is held off only while results are waiting
    a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    // After a taken byte that yields a result, a result is valid on the next cycle
    a_result_follows : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (push.count != 2'd0)) |=> m_tvalid)
        else $error("result lost after accepted byte");

endmodule

`default_nettype wire

[verif/csaip_aux_info_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// csaip_aux_info_checker
// Watches both streams of the aux info parser. Every header byte beat is run
// through a cycle-free parser of its own to build the expected results, and
// every result beat is compared, field by field, with the oldest expectation.
// ----------------------------------------------------------------------------

module csaip_aux_info_checker
(
    input  wire logic         clk,
    input  wire logic         rst_n,

    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [31:0]  s_tdata,   // data_byte[7:0], sample_size[31:8]
    input  wire logic         s_tuser,   // start_req

    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [135:0] m_tdata,   // iv_index, iv_value, entry_index, clear_size,
                                         // encrypted_bytes, entry_total, header_length,
                                         // remaining_size, error
    input  wire logic [1:0]   m_tuser,   // kind
    input  wire logic         m_tlast,   // last

    output int                mismatch_count,
    output int                results_pending
);

    // Parser state, reset values as after rst_n
    csaip_pkg::phase_t parse_phase = csaip_pkg::PH_IDLE;
    logic         subsamples_on = 1'b0;
    logic [6:0]   iv_len        = '0;
    logic [6:0]   field_bytes   = '0;
    logic [15:0]  entry_cnt     = '0;
    logic [15:0]  entry_pos     = '0;
    logic [47:0]  field_shift   = '0;
    logic [18:0]  consumed      = '0;
    logic [23:0]  sample_bytes  = '0;
    logic         hdr_error     = 1'b0;

    int           mismatches    = 0;
    int           pending       = 0;

    csaip_pkg::result_t expected_results[$];

    assign mismatch_count  = mismatches;
    assign results_pending = pending;

    function automatic logic [23:0] bytes_left();
        if ({5'd0, consumed} >= sample_bytes)
            return '0;
        return sample_bytes - 24'(consumed);
    endfunction

    // Each header byte counts against the sample; overrun flags the header
    task count_byte();
        consumed = consumed + 19'd1;
        if ({5'd0, consumed} > sample_bytes)
            hdr_error = 1'b1;
    endtask

    task add_result(input csaip_pkg::kind_t k, input logic [3:0] ivi,
                    input logic [7:0] ivv,
                    input logic [15:0] ei, input logic [15:0] clr,
                    input logic [31:0] enc, input logic [15:0] tot, input logic lst);
        csaip_pkg::result_t r;
        r.kind            = k;
        r.iv_index        = ivi;
        r.iv_value        = ivv;
        r.entry_index     = ei;
        r.clear_size      = clr;
        r.encrypted_bytes = enc;
        r.entry_total     = tot;
        r.header_length   = consumed;
        r.remaining_size  = bytes_left();
        r.last            = lst;
        r.error           = hdr_error;
        expected_results  = {expected_results, r};
    endtask

    // End of IV: count field next, or the one implied entry without subsamples
    task finish_iv();
        field_bytes = '0;
        field_shift = '0;
        if (subsamples_on)
            parse_phase = csaip_pkg::PH_COUNT;
        else
        begin
            parse_phase = csaip_pkg::PH_IDLE;
            entry_cnt   = 16'd1;
            add_result(csaip_pkg::KIND_ENTRY, '0, '0, '0, '0, {8'd0, bytes_left()},
                       16'd1, 1'b1);
        end
    endtask

    task take_byte(input logic [7:0] b, input logic start, input logic [23:0] size);
        logic [6:0] idx;
        logic       lst;
        if (start)
        begin
            // A start always opens a new header, whatever was in progress
            subsamples_on = b[7];
            iv_len        = b[6:0];
            sample_bytes  = size;
            hdr_error     = 1'b0;
            consumed      = '0;
            entry_cnt     = '0;
            entry_pos     = '0;
            field_shift   = '0;
            field_bytes   = '0;
            count_byte();
            if (iv_len > csaip_pkg::IV_BYTES)
                hdr_error = 1'b1;
            if (iv_len == '0)
                finish_iv();
            else
                parse_phase = csaip_pkg::PH_IV;
        end
        else
        begin
            case (parse_phase)
                csaip_pkg::PH_IV:
                begin
                    count_byte();
                    idx         = field_bytes;
                    field_bytes = field_bytes + 7'd1;
                    // IV bytes past the vector are swallowed silently
                    if (idx < csaip_pkg::IV_BYTES)
                        add_result(csaip_pkg::KIND_IV, idx[3:0], b, '0, '0, '0, '0, 1'b0);
                    if (field_bytes >= iv_len)
                        finish_iv();
                end
                csaip_pkg::PH_COUNT:
                begin
                    count_byte();
                    field_shift = {32'd0, field_shift[7:0], b};
                    field_bytes = field_bytes + 7'd1;
                    if (field_bytes >= csaip_pkg::COUNT_BYTES)
                    begin
                        entry_cnt   = field_shift[15:0];
                        entry_pos   = '0;
                        field_bytes = '0;
                        field_shift = '0;
                        if (entry_cnt == '0)
                        begin
                            parse_phase = csaip_pkg::PH_IDLE;
                            add_result(csaip_pkg::KIND_END, '0, '0, '0, '0, '0, '0, 1'b1);
                        end
                        else
                            parse_phase = csaip_pkg::PH_ENTRY;
                    end
                end
                csaip_pkg::PH_ENTRY:
                begin
                    count_byte();
                    field_shift = {field_shift[39:0], b};
                    field_bytes = field_bytes + 7'd1;
                    if (field_bytes >= csaip_pkg::ENTRY_BYTES)
                    begin
                        lst = ({1'b0, entry_pos} + 17'd1 == {1'b0, entry_cnt});
                        add_result(csaip_pkg::KIND_ENTRY, '0, '0, entry_pos,
                                   field_shift[47:32], field_shift[31:0], entry_cnt, lst);
                        field_bytes = '0;
                        field_shift = '0;
                        entry_pos   = entry_pos + 16'd1;
                        if (lst)
                            parse_phase = csaip_pkg::PH_IDLE;
                    end
                end
                default: ;  // idle bytes without start are dropped
            endcase
        end
    endtask

    task check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    task check_result();
        csaip_pkg::result_t got;
        csaip_pkg::result_t want;
        got.kind            = csaip_pkg::kind_t'(m_tuser);
        got.iv_index        = m_tdata[3:0];
        got.iv_value        = m_tdata[11:4];
        got.entry_index     = m_tdata[27:12];
        got.clear_size      = m_tdata[43:28];
        got.encrypted_bytes = m_tdata[75:44];
        got.entry_total     = m_tdata[91:76];
        got.header_length   = m_tdata[110:92];
        got.remaining_size  = m_tdata[134:111];
        got.error           = m_tdata[135];
        got.last            = m_tlast;
        if (expected_results.size() == 0)
        begin
            mismatches++;
            $display("%0t: result beat with none expected, kind %0d tdata %h",
                     $time, m_tuser, m_tdata);
        end
        else
        begin
            want = expected_results[0];
            expected_results.delete(0);
            check_field("kind",            32'(want.kind),            32'(got.kind));
            check_field("iv_index",        32'(want.iv_index),        32'(got.iv_index));
            check_field("iv_value",        32'(want.iv_value),        32'(got.iv_value));
            check_field("entry_index",     32'(want.entry_index),     32'(got.entry_index));
            check_field("clear_size",      32'(want.clear_size),      32'(got.clear_size));
            check_field("encrypted_bytes", want.encrypted_bytes,      got.encrypted_bytes);
            check_field("entry_total",     32'(want.entry_total),     32'(got.entry_total));
            check_field("header_length",   32'(want.header_length),   32'(got.header_length));
            check_field("remaining_size",  32'(want.remaining_size),  32'(got.remaining_size));
            check_field("last",            32'(want.last),            32'(got.last));
            check_field("error",           32'(want.error),           32'(got.error));
        end
    endtask

    // Results are registered after their byte is taken, so checking before predicting
    // at the same edge keeps a stray result from meeting a fresh expectation
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                check_result();
            if (s_tvalid && s_tready)
                take_byte(s_tdata[7:0], s_tuser, s_tdata[31:8]);
            pending = expected_results.size();
        end
    end

endmodule

[verif/tb_cenc_sample_aux_info_parser.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cenc_sample_aux_info_parser
// Drives header byte streams into the aux info parser: a short directed run
// over the corner cases, then random headers, mostly well formed with some
// cut short and some noise, under random idling on both sides and one long
// receiver hold-off. Checking lives in csaip_aux_info_checker.
// ----------------------------------------------------------------------------

module tb_cenc_sample_aux_info_parser;

    localparam int HEADER_BEATS = 1800;  // random part runs until this many bytes
    localparam int IDLE_LIMIT   = 3000;  // cycles with no beat on either side
    localparam int HOLD_CYCLES  = 400;   // the one long receiver hold-off

    logic         clk;
    logic         rst_n;

    logic         s_tvalid;
    logic         s_tready;
    logic [31:0]  s_tdata;    // data_byte[7:0], sample_size[31:8]
    logic         s_tuser;    // start_req

    logic         m_tvalid;
    logic         m_tready;
    logic [135:0] m_tdata;    // iv_index[3:0] .. error[135], see the block
    logic [1:0]   m_tuser;    // kind
    logic         m_tlast;    // last

    int           mismatch_count;
    int           results_pending;
    int           header_beats = 0;

    bit           flat_run    = 1'b0;  // header sent back to back, no gaps
    bit           hold_req    = 1'b0;  // ask the receiver for its long hold-off
    bit           hold_active = 1'b0;  // receiver is holding off right now

    cenc_sample_aux_info_parser u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    csaip_aux_info_checker u_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // One byte beat. Inputs change on the falling edge only; the gap before
    // the beat is skipped in back-to-back runs and during the hold-off, so the
    // result queue fills and the input stalls.
    task automatic send_beat(input logic [7:0] data, input logic start,
                             input logic [23:0] size);
        int sel;
        int gap;
        gap = 0;
        if (!flat_run && !hold_active)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 60)
                gap = 0;
            else if (sel < 90)
                gap = $urandom_range(1, 3);
            else if (sel < 98)
                gap = $urandom_range(4, 10);
            else
                gap = $urandom_range(20, 60);
        end
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {size, data};
        s_tuser  = start;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // One random header. Most are complete; a broken one carries a random
    // count if it has subsamples and is cut anywhere, to be dropped by the next start.
    task automatic send_header();
        logic [7:0]  hdr[$];
        logic [15:0] count_field;
        logic [23:0] size;
        logic        subs;
        bit          broken;
        int          iv_len;
        int          n_entries;
        int          sel;
        int          hdr_len;
        int          cut;
        subs   = $urandom_range(0, 1);
        broken = ($urandom_range(0, 6) == 0);
        sel    = $urandom_range(0, 9);
        case (sel)
            0:       iv_len = 0;
            1:       iv_len = 8;
            2:       iv_len = csaip_pkg::IV_BYTES;
            3:       iv_len = $urandom_range(csaip_pkg::IV_BYTES + 1, 127);  // over-long IV
            default: iv_len = $urandom_range(1, csaip_pkg::IV_BYTES);
        endcase
        hdr = {hdr, {subs, 7'(iv_len)}};
        repeat (iv_len) hdr = {hdr, 8'($urandom)};
        if (subs)
        begin
            sel = $urandom_range(0, 9);
            if (broken)
                count_field = 16'($urandom);
            else if (sel == 0)
                count_field = 16'd0;
            else if (sel == 1)
                count_field = 16'($urandom_range(5, 12));
            else
                count_field = 16'($urandom_range(1, 4));
            hdr = {hdr, count_field[15:8]};
            hdr = {hdr, count_field[7:0]};
            n_entries = (broken && count_field > 3) ? 3 : int'(count_field);
            repeat (n_entries * 6) hdr = {hdr, 8'($urandom)};
        end
        hdr_len = hdr.size();
        sel     = $urandom_range(0, 9);
        if (sel == 0)
            size = 24'($urandom_range(0, hdr_len));     // header may overrun sample
        else if (sel == 1)
            size = $urandom_range(0, 1) ? 24'hFFFFFF : 24'($urandom);
        else
            size = 24'(hdr_len + $urandom_range(0, 1000));
        if (broken)
        begin
            cut = $urandom_range(1, hdr_len);
            hdr = hdr[0:cut-1];
        end
        flat_run = ($urandom_range(0, 3) == 0);
        foreach (hdr[i])
            send_beat(hdr[i], i == 0, (i == 0) ? size : 24'($urandom));
        flat_run = 1'b0;
        header_beats += hdr.size();
    endtask

    // Stimulus and verdict
    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // idle byte without start: ignored
        send_beat(8'h5A, 1'b0, 24'hFFFFFF);
        // empty IV, no subsamples: single entry at once; zero and full sample size
        send_beat(8'h00, 1'b1, 24'h000000);
        send_beat(8'h00, 1'b1, 24'hFFFFFF);
        // empty IV with subsamples, zero count: end-of-header result
        send_beat(8'h80, 1'b1, 24'd100);
        send_beat(8'h00, 1'b0, 24'd0);
        send_beat(8'h00, 1'b0, 24'd0);
        // two-byte IV in a two-byte sample: overrun on the last IV byte
        send_beat(8'h02, 1'b1, 24'd2);
        send_beat(8'h00, 1'b0, 24'hFFFFFF);
        send_beat(8'hFF, 1'b0, 24'h000000);
        // one IV byte, one subsample with all-ones sizes
        send_beat(8'h81, 1'b1, 24'd20);
        send_beat(8'hA5, 1'b0, 24'd0);
        send_beat(8'h00, 1'b0, 24'd0);
        send_beat(8'h01, 1'b0, 24'd0);
        repeat (6) send_beat(8'hFF, 1'b0, 24'd0);
        // longest IV with subsamples, broken off by a new start
        send_beat(8'hFF, 1'b1, 24'd5);
        send_beat(8'h3C, 1'b0, 24'd0);
        send_beat(8'hC3, 1'b0, 24'd0);
        send_beat(8'h01, 1'b1, 24'h800000);
        send_beat(8'h7E, 1'b0, 24'd0);

        hold_req = 1'b1;
        while (header_beats < HEADER_BEATS)
        begin
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 5))
                    send_beat(8'($urandom), $urandom_range(0, 7) == 0, 24'($urandom));
            send_header();
        end
        s_tvalid = 1'b0;

        while (results_pending != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (mismatch_count == 0 && results_pending == 0)
            $display("cenc_sample_aux_info_parser: match");
        else
            $display("cenc_sample_aux_info_parser: mismatch");
        $finish;
    end

    // Receiver: random stalls, some calm stretches, and one long hold-off
    initial
    begin
        int stall_left;
        int hold_left;
        int cyc;
        int sel;
        bit steady;
        bit hold_done;
        stall_left = 0;
        hold_left  = 0;
        cyc        = 0;
        steady     = 1'b0;
        hold_done  = 1'b0;
        m_tready   = 1'b0;
        forever
        begin
            @(negedge clk);
            cyc++;
            if (cyc % 300 == 0)
                steady = ($urandom_range(0, 3) == 0);
            if (hold_req && !hold_done)
            begin
                hold_done   = 1'b1;
                hold_left   = HOLD_CYCLES;
                hold_active = 1'b1;
            end
            if (hold_left > 0)
            begin
                m_tready = 1'b0;
                hold_left--;
                if (hold_left == 0)
                    hold_active = 1'b0;
            end
            else if (stall_left > 0)
            begin
                m_tready = 1'b0;
                stall_left--;
            end
            else if (steady)
                m_tready = 1'b1;
            else
            begin
                sel = $urandom_range(0, 99);
                if (sel < 65)
                    m_tready = 1'b1;
                else
                begin
                    m_tready   = 1'b0;
                    stall_left = (sel < 93) ? $urandom_range(0, 2) : $urandom_range(7, 39);
                end
            end
        end
    end

    // Watchdog: too long without a beat on either side means a hang
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("cenc_sample_aux_info_parser: mismatch");
        $finish;
    end

endmodule
